// ===== src/prl_pkg.sv =====
// ----------------------------------------------------------------------------
// prl_pkg
// Types and constants shared by the packet rate limiter modules.
// ----------------------------------------------------------------------------
package prl_pkg;

	localparam int unsigned TableSets = 1024;
	localparam int unsigned TableWays = 4;
	localparam int unsigned SetBits   = (TableSets > 1) ? $clog2(TableSets) : 1;
	localparam int unsigned WayBits   = (TableWays > 1) ? $clog2(TableWays) : 1;
	localparam int unsigned AgeBits   = WayBits;

	localparam logic [31:0] WindowReset = 32'd1000000000;

	typedef enum logic [2:0] {
		REG_LICENSE  = 3'd0,
		REG_LIMITING = 3'd1,
		REG_GLOBAL   = 3'd2,
		REG_SOURCE   = 3'd3,
		REG_WINDOW   = 3'd4,
		REG_BURST    = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		CAUSE_NONE   = 2'd0,
		CAUSE_GLOBAL = 2'd1,
		CAUSE_SOURCE = 2'd2
	} cause_t;

	typedef struct packed {
		logic        is_ipv4;
		logic [31:0] src_addr;
		logic [63:0] timestamp_ns;
	} in_word_t;

	typedef struct packed {
		logic        verdict;
		logic [1:0]  drop_cause;
		logic [63:0] stat_total;
		logic [63:0] stat_passed;
		logic [63:0] stat_dropped;
		logic [63:0] stat_global_drops;
		logic [63:0] stat_source_drops;
	} out_word_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [31:0] data;
	} cfg_word_t;

	// one way of the source table as stored in memory
	typedef struct packed {
		logic [31:0] addr;
		logic [63:0] window_start;
		logic [31:0] window_count;
		logic [31:0] burst_left;
		logic [31:0] seen;
		logic [31:0] dropped;
	} entry_t;

	// per-set bookkeeping kept in flip-flops
	typedef struct packed {
		logic [TableWays-1:0]              valid;
		logic [TableWays-1:0][AgeBits-1:0] age;
	} set_meta_t;

	function automatic logic [31:0] inc32(input logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	function automatic logic [63:0] inc64(input logic [63:0] v);
		return (v == '1) ? v : v + 64'd1;
	endfunction

endpackage

// ===== src/prl_table.sv =====
// ----------------------------------------------------------------------------
// prl_table
// Per-source table: one entry memory per way, registered synchronous read.
// ----------------------------------------------------------------------------
module prl_table (
	input  logic                                   clk,
	input  logic                                   rd_en,
	input  logic [prl_pkg::SetBits-1:0]            rd_set,
	output prl_pkg::entry_t [prl_pkg::TableWays-1:0] rd_data,
	input  logic                                   wr_en,
	input  logic [prl_pkg::SetBits-1:0]            wr_set,
	input  logic [prl_pkg::WayBits-1:0]            wr_way,
	input  prl_pkg::entry_t                        wr_data
);
	import prl_pkg::*;

	for (genvar w = 0; w < TableWays; w++) begin : g_way
		entry_t mem [TableSets];

		always_ff @(posedge clk) begin
			if (wr_en && (wr_way == WayBits'(w))) begin
				mem[wr_set] <= wr_data;
			end
			if (rd_en) begin
				rd_data[w] <= mem[rd_set];
			end
		end
	end

endmodule

// ===== src/packet_rate_limiter.sv =====
// ----------------------------------------------------------------------------
// packet_rate_limiter
// Fixed-window packet rate limiter with per-source burst allowance.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one packet event word (IPv4 flag,
// source address, timestamp); output channel out_valid/out_ready returns one
// verdict word per packet with cause and five saturating statistics.
// cfg_valid/cfg_ready writes one of six registers by index; write only while
// the block is idle.
// The edge that accepts a packet also starts the read of its set; the next
// edge runs the global and per-source checks and, for a counted packet that
// passed the global check with a source limit set, writes the way back; the
// edge after that registers the result and raises out_valid. One packet is
// in flight at a time and in_ready stays low while a result waits, so a new
// packet is accepted only after the previous result has been taken.
// After reset a clearing pass zeroes the valid and age bits of one set per
// cycle over all 1024 sets, with in_ready held low; the entry memory is not
// cleared. The global window starts at time 0.
// When the receiver stalls, the result word holds in the output register
// and no new packet is accepted until it is taken.
// ----------------------------------------------------------------------------
module packet_rate_limiter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  prl_pkg::in_word_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output prl_pkg::out_word_t  out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  prl_pkg::cfg_word_t  cfg_data
);
	import prl_pkg::*;

	// configuration
	logic        license_q, limiting_q;
	logic [31:0] glimit_q, slimit_q, window_q, burst_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			license_q  <= 1'b0;
			limiting_q <= 1'b0;
			glimit_q   <= '0;
			slimit_q   <= '0;
			window_q   <= WindowReset;
			burst_q    <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_data.index)
				REG_LICENSE:  license_q  <= cfg_data.data[0];
				REG_LIMITING: limiting_q <= cfg_data.data[0];
				REG_GLOBAL:   glimit_q   <= cfg_data.data;
				REG_SOURCE:   slimit_q   <= cfg_data.data;
				REG_WINDOW:   window_q   <= cfg_data.data;
				REG_BURST:    burst_q    <= cfg_data.data;
				default: ;
			endcase
		end
	end

	// clear the set bookkeeping one set per cycle after reset
	logic               clearing_q;
	logic [SetBits-1:0] clr_set_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_set_q  <= '0;
		end else if (clearing_q) begin
			clr_set_q <= clr_set_q + SetBits'(1);
			if (clr_set_q == SetBits'(TableSets - 1)) clearing_q <= 1'b0;
		end
	end

	// pipeline control
	logic     busy_s1, busy_s2;
	in_word_t pkt_s1;
	logic     take;

	assign in_ready = !clearing_q && !busy_s1 && !busy_s2 && !out_valid;
	assign take     = in_valid && in_ready;

	logic [SetBits-1:0] rd_set;
	assign rd_set = SetBits'(in_data.src_addr % TableSets);

	entry_t [TableWays-1:0] rd_data;
	logic                   wr_en;
	logic [WayBits-1:0]     wr_way;
	entry_t                 wr_data;
	logic [SetBits-1:0]     set_s1;

	prl_table u_table (
		.clk     (clk),
		.rd_en   (take),
		.rd_set  (rd_set),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_set  (set_s1),
		.wr_way  (wr_way),
		.wr_data (wr_data)
	);

	set_meta_t meta_mem [TableSets];
	set_meta_t meta_s1;

	// global state and statistics
	logic [63:0] gstart_q;
	logic [31:0] gcount_q, gseen_q, gdrop_q;
	logic [63:0] st_total_q, st_pass_q, st_drop_q, st_gdrop_q, st_sdrop_q;

	// stage 1 evaluation
	logic                  counted, gdrop, sdrop, src_on;
	logic                  g_new;
	logic [31:0]           g_cnt;
	logic                  hit, has_free;
	logic [WayBits-1:0]    hit_way, free_way, old_way, pick;
	entry_t                cur, nxt;
	logic [31:0]           s_cnt;
	logic                  s_new;
	set_meta_t             meta_nxt;
	logic [AgeBits-1:0]    old_age;
	logic [63:0]           set_span;

	assign set_span = pkt_s1.timestamp_ns - cur.window_start;

	always_comb begin
		counted = license_q && limiting_q && pkt_s1.is_ipv4;
		g_new   = (pkt_s1.timestamp_ns - gstart_q) >= {32'd0, window_q};
		g_cnt   = g_new ? 32'd1 : inc32(gcount_q);
		gdrop   = counted && (glimit_q != '0) && (g_cnt > glimit_q);
		src_on  = counted && !gdrop && (slimit_q != '0);

		hit = 1'b0; hit_way = '0;
		for (int w = TableWays - 1; w >= 0; w--) begin
			if (meta_s1.valid[w] && rd_data[w].addr == pkt_s1.src_addr) begin
				hit = 1'b1; hit_way = WayBits'(w);
			end
		end
		has_free = 1'b0; free_way = '0;
		for (int w = TableWays - 1; w >= 0; w--) begin
			if (!meta_s1.valid[w]) begin
				has_free = 1'b1; free_way = WayBits'(w);
			end
		end
		old_way = '0;
		for (int w = 1; w < TableWays; w++) begin
			if (meta_s1.age[w] > meta_s1.age[old_way]) old_way = WayBits'(w);
		end
		pick = hit ? hit_way : (has_free ? free_way : old_way);

		cur   = rd_data[pick];
		nxt   = cur;
		sdrop = 1'b0;
		s_new = set_span >= {32'd0, window_q};
		s_cnt = s_new ? 32'd1 : inc32(cur.window_count);
		if (!hit) begin
			nxt.addr         = pkt_s1.src_addr;
			nxt.window_start = pkt_s1.timestamp_ns;
			nxt.window_count = 32'd1;
			nxt.burst_left   = burst_q;
			nxt.seen         = 32'd1;
			nxt.dropped      = '0;
		end else begin
			nxt.window_count = s_cnt;
			if (s_new) begin
				nxt.window_start = pkt_s1.timestamp_ns;
				nxt.burst_left   = burst_q;
			end
			nxt.seen = inc32(cur.seen);
			if (s_cnt > slimit_q) begin
				if (nxt.burst_left != '0) begin
					nxt.burst_left = nxt.burst_left - 32'd1;
				end else begin
					nxt.dropped = inc32(cur.dropped);
					sdrop       = src_on;
				end
			end
		end

		// age the valid ways that were newer than the touched one
		old_age  = meta_s1.valid[pick] ? meta_s1.age[pick] : AgeBits'(TableWays - 1);
		meta_nxt = meta_s1;
		for (int w = 0; w < TableWays; w++) begin
			if (WayBits'(w) != pick && meta_s1.valid[w] && meta_s1.age[w] < old_age)
				meta_nxt.age[w] = meta_s1.age[w] + AgeBits'(1);
		end
		meta_nxt.age[pick]   = '0;
		meta_nxt.valid[pick] = 1'b1;

		wr_en   = busy_s1 && src_on;
		wr_way  = pick;
		wr_data = nxt;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pkt_s1 <= in_data;
			set_s1 <= rd_set;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) meta_mem[clr_set_q] <= '0;
		else if (wr_en) meta_mem[set_s1] <= meta_nxt;
		if (take) meta_s1 <= meta_mem[rd_set];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1    <= 1'b0;
			busy_s2    <= 1'b0;
			out_valid  <= 1'b0;
			gstart_q   <= '0;
			gcount_q   <= '0;
			gseen_q    <= '0;
			gdrop_q    <= '0;
			st_total_q <= '0;
			st_pass_q  <= '0;
			st_drop_q  <= '0;
			st_gdrop_q <= '0;
			st_sdrop_q <= '0;
		end else begin
			busy_s1 <= take;
			busy_s2 <= busy_s1;
			if (busy_s2) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			if (busy_s1 && counted) begin
				if (glimit_q != '0) begin
					gcount_q <= g_cnt;
					gseen_q  <= inc32(gseen_q);
					if (g_new) gstart_q <= pkt_s1.timestamp_ns;
					if (gdrop) gdrop_q <= inc32(gdrop_q);
				end
				st_total_q <= inc64(st_total_q);
				if (gdrop || sdrop) begin
					st_drop_q <= inc64(st_drop_q);
					if (gdrop) st_gdrop_q <= inc64(st_gdrop_q);
					else       st_sdrop_q <= inc64(st_sdrop_q);
				end else begin
					st_pass_q <= inc64(st_pass_q);
				end
			end
		end
	end

	// result verdict registered alongside the statistics
	logic   verdict_s2;
	cause_t cause_s2;

	always_ff @(posedge clk) begin
		if (busy_s1) begin
			verdict_s2 <= gdrop || sdrop;
			cause_s2   <= gdrop ? CAUSE_GLOBAL : (sdrop ? CAUSE_SOURCE : CAUSE_NONE);
		end
		if (busy_s2) begin
			out_data.verdict           <= verdict_s2;
			out_data.drop_cause        <= cause_s2;
			out_data.stat_total        <= st_total_q;
			out_data.stat_passed       <= st_pass_q;
			out_data.stat_dropped      <= st_drop_q;
			out_data.stat_global_drops <= st_gdrop_q;
			out_data.stat_source_drops <= st_sdrop_q;
		end
	end

	logic unused_ok;
	assign unused_ok = ^{gseen_q, gdrop_q};

endmodule

// ===== sim/tb_packet_rate_limiter.sv =====
// ----------------------------------------------------------------------------
// tb_packet_rate_limiter
// Self-checking bench for the packet rate limiter: a behavioral predictor
// tracks the window counters, the per-source LRU table and the statistics,
// and every verdict word is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_packet_rate_limiter;
	timeunit 1ns;
	timeprecision 1ps;
	import prl_pkg::*;

	localparam int unsigned CycleLimit = 400000;

	class verdict_board;
		bit          lic, lim;
		logic [31:0] glim, slim, wlen, burst;
		bit          e_valid [TableSets][TableWays];
		logic [31:0] e_addr  [TableSets][TableWays];
		logic [63:0] e_start [TableSets][TableWays];
		logic [31:0] e_count [TableSets][TableWays];
		logic [31:0] e_burst [TableSets][TableWays];
		int unsigned e_age   [TableSets][TableWays];
		logic [63:0] g_start;
		logic [31:0] g_count;
		logic [63:0] st_total, st_pass, st_drop, st_gdrop, st_sdrop;
		out_word_t   pending[$];
		int          errors;

		function void clear();
			lic = 0; lim = 0; glim = 0; slim = 0; wlen = WindowReset; burst = 0;
			foreach (e_valid[s, w]) begin
				e_valid[s][w] = 0;
				e_age[s][w] = 0;
			end
			g_start = 0; g_count = 0;
			st_total = 0; st_pass = 0; st_drop = 0; st_gdrop = 0; st_sdrop = 0;
			errors = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [31:0] val);
			case (idx)
				REG_LICENSE: lic = val[0];
				REG_LIMITING: lim = val[0];
				REG_GLOBAL: glim = val;
				REG_SOURCE: slim = val;
				REG_WINDOW: wlen = val;
				REG_BURST: burst = val;
				default: ;
			endcase
		endfunction

		function logic [31:0] sat32(logic [31:0] v);
			return (v == '1) ? v : v + 1;
		endfunction

		function logic [63:0] sat64(logic [63:0] v);
			return (v == '1) ? v : v + 1;
		endfunction

		function void make_recent(int unsigned s, int unsigned w);
			int unsigned old;
			old = e_valid[s][w] ? e_age[s][w] : TableWays - 1;
			for (int unsigned v = 0; v < TableWays; v++)
				if (v != w && e_valid[s][v] && e_age[s][v] < old)
					e_age[s][v]++;
			e_age[s][w] = 0;
		endfunction

		function bit over_source(logic [31:0] addr, logic [63:0] now);
			int unsigned s, pick;
			bit hit;
			s = addr % TableSets;
			hit = 0;
			pick = 0;
			for (int unsigned w = 0; w < TableWays; w++)
				if (!hit && e_valid[s][w] && e_addr[s][w] == addr) begin
					pick = w;
					hit = 1;
				end
			if (!hit) begin
				bit free;
				free = 0;
				for (int unsigned w = 0; w < TableWays; w++)
					if (!free && !e_valid[s][w]) begin
						pick = w;
						free = 1;
					end
				if (!free) begin
					pick = 0;
					for (int unsigned w = 1; w < TableWays; w++)
						if (e_age[s][w] > e_age[s][pick])
							pick = w;
				end
				make_recent(s, pick);
				e_valid[s][pick] = 1;
				e_addr[s][pick] = addr;
				e_start[s][pick] = now;
				e_count[s][pick] = 1;
				e_burst[s][pick] = burst;
				return 0;
			end
			make_recent(s, pick);
			if (now - e_start[s][pick] >= {32'd0, wlen}) begin
				e_start[s][pick] = now;
				e_count[s][pick] = 1;
				e_burst[s][pick] = burst;
			end else
				e_count[s][pick] = sat32(e_count[s][pick]);
			if (e_count[s][pick] > slim) begin
				if (e_burst[s][pick] > 0)
					e_burst[s][pick]--;
				else
					return 1;
			end
			return 0;
		endfunction

		function void note_packet(in_word_t p);
			out_word_t r;
			r = '0;
			if (lic && lim && p.is_ipv4) begin
				if (glim != 0) begin
					if (p.timestamp_ns - g_start >= {32'd0, wlen}) begin
						g_start = p.timestamp_ns;
						g_count = 1;
					end else
						g_count = sat32(g_count);
					if (g_count > glim) begin
						r.verdict = 1;
						r.drop_cause = CAUSE_GLOBAL;
					end
				end
				if (!r.verdict && slim != 0 && over_source(p.src_addr, p.timestamp_ns)) begin
					r.verdict = 1;
					r.drop_cause = CAUSE_SOURCE;
				end
				st_total = sat64(st_total);
				if (r.verdict) begin
					st_drop = sat64(st_drop);
					if (r.drop_cause == CAUSE_GLOBAL)
						st_gdrop = sat64(st_gdrop);
					else
						st_sdrop = sat64(st_sdrop);
				end else
					st_pass = sat64(st_pass);
			end
			r.stat_total = st_total;
			r.stat_passed = st_pass;
			r.stat_dropped = st_drop;
			r.stat_global_drops = st_gdrop;
			r.stat_source_drops = st_sdrop;
			pending.push_back(r);
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			errors++;
			$display("mismatch %s: got %0h expected %0h", what, got, want);
		endtask

		task check_verdict(out_word_t got);
			out_word_t want;
			if (pending.size() == 0) begin
				report("unexpected word", got.stat_total, 0);
				return;
			end
			want = pending.pop_front();
			if (got.verdict !== want.verdict) report("verdict", got.verdict, want.verdict);
			if (got.drop_cause !== want.drop_cause)
				report("drop_cause", got.drop_cause, want.drop_cause);
			if (got.stat_total !== want.stat_total)
				report("stat_total", got.stat_total, want.stat_total);
			if (got.stat_passed !== want.stat_passed)
				report("stat_passed", got.stat_passed, want.stat_passed);
			if (got.stat_dropped !== want.stat_dropped)
				report("stat_dropped", got.stat_dropped, want.stat_dropped);
			if (got.stat_global_drops !== want.stat_global_drops)
				report("stat_global_drops", got.stat_global_drops, want.stat_global_drops);
			if (got.stat_source_drops !== want.stat_source_drops)
				report("stat_source_drops", got.stat_source_drops, want.stat_source_drops);
		endtask
	endclass

	logic      clk = 0;
	logic      arst_n = 0;
	logic      in_valid = 0;
	logic      in_ready;
	in_word_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 0;
	out_word_t out_data;
	logic      cfg_valid = 0;
	logic      cfg_ready;
	cfg_word_t cfg_data = '0;

	verdict_board board;
	bit          calm = 0;
	bit          hold_off = 0;
	int unsigned cycles = 0;
	logic [63:0] clock_ns = 0;
	logic [31:0] addr_pool[8];

	packet_rate_limiter dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off on request
	initial begin
		int unsigned gap;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off)
				out_ready <= 0;
			else if (!calm && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 15);
				out_ready <= 0;
				repeat (gap) @(posedge clk);
				out_ready <= 1;
			end else
				out_ready <= 1;
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			board.check_verdict(out_data);

	// drop valid after the write so the next write starts cleanly
	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		cfg_valid <= 1;
		cfg_data <= '{index: idx, data: val};
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, val);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	// valid stays up after acceptance until the next word or an idle gap
	task automatic send(logic ipv4, logic [31:0] addr, logic [63:0] ts);
		in_valid <= 1;
		in_data <= '{is_ipv4: ipv4, src_addr: addr, timestamp_ns: ts};
		do @(posedge clk); while (!in_ready);
		board.note_packet('{is_ipv4: ipv4, src_addr: addr, timestamp_ns: ts});
		if (!calm && $urandom_range(0, 7) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic setup(bit lic, bit lim, logic [31:0] g, logic [31:0] s, logic [31:0] w,
			logic [31:0] b);
		drain();
		write_reg(REG_LICENSE, lic);
		write_reg(REG_LIMITING, lim);
		write_reg(REG_GLOBAL, g);
		write_reg(REG_SOURCE, s);
		write_reg(REG_WINDOW, w);
		write_reg(REG_BURST, b);
	endtask

	// mostly small forward steps over a small pool of sources
	task automatic random_run(int unsigned n);
		logic [31:0] addr;
		for (int unsigned i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0: addr = $urandom();
				1: addr = addr_pool[$urandom_range(0, 7)] + TableSets * $urandom_range(1, 6);
				default: addr = addr_pool[$urandom_range(0, 7)];
			endcase
			case ($urandom_range(0, 19))
				0: clock_ns = {$urandom(), $urandom()};
				1: clock_ns = clock_ns - $urandom_range(1, 50);
				default: clock_ns = clock_ns + $urandom_range(0, 40);
			endcase
			send($urandom_range(0, 15) != 0, addr, clock_ns);
		end
	endtask

	initial begin
		board = new();
		board.clear();
		foreach (addr_pool[i]) addr_pool[i] = $urandom();
		addr_pool[0] = '0;
		addr_pool[1] = '1;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: untouched pass, then limits at their extremes
		send(1, 32'h0A000001, 64'd5);
		setup(1, 1, 0, 0, 32'd100, 0);
		send(0, '1, '1);
		send(1, 32'h0A000001, 64'd0);
		drain();
		write_reg(REG_LICENSE, 0);
		send(1, 32'h0A000001, 64'd1);
		setup(1, 1, 32'd2, 0, 32'd100, 0);
		send(1, 32'd7, 64'd10);
		send(1, 32'd7, 64'd20);
		send(1, 32'd7, 64'd30);        // global drop
		send(1, 32'd7, 64'd200);       // window elapsed
		send(1, 32'd7, 64'd5);         // timestamp moves backwards
		setup(1, 1, 0, 32'd1, 32'd1000, 32'd1);
		send(1, 32'd3, 64'd0);         // first packet of a source passes
		send(1, 32'd3, 64'd1);         // burst token spent
		send(1, 32'd3, 64'd2);         // per-source drop
		for (int i = 1; i <= 5; i++)   // evict the oldest way of set 3
			send(1, 32'd3 + i * TableSets, 64'd3);
		send(1, 32'd3, 64'd4);
		setup(1, 1, '1, '1, 32'd0, '1); // zero window length
		send(1, '1, '1);
		send(1, '1, 64'd0);
		setup(1, 1, 32'd1, 32'd1, '1, 0);
		send(1, '0, '1);
		send(1, '0, 64'd0);

		// random phases over several settings
		setup(1, 1, 32'd20, 32'd3, 32'd200, 32'd2);
		random_run(300);
		// fill the block while the receiver holds off
		hold_off = 1;
		fork
			random_run(20);
			begin
				repeat (200) @(posedge clk);
				hold_off = 0;
			end
		join
		setup(1, 1, 0, 32'd2, 32'd100, 0);
		random_run(300);
		setup(1, 1, 32'd5, 0, 32'd50, 32'd7);
		random_run(250);
		setup(1, 1, 32'd4, 32'd1, 32'd300, 32'd1);
		random_run(300);
		setup(1, 1, '1, '1, '1, '1);
		random_run(100);
		setup(1, 1, 32'd1, 32'd1, 32'd1, 0);
		random_run(100);
		setup(0, 1, 32'd1, 32'd1, 32'd100, 0);
		random_run(50);
		setup(1, 1, 32'd30, 32'd2, 32'd400, 32'd3);
		calm = 1;
		random_run(250);
		drain();
		if (board.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
